// File: rtl/dds_tcs_pkg.sv
// Shared types, constants and word builders for the DDS tuning command sequencer.
// No dependencies; imported by every RTL module and the checker.
`default_nettype none

package dds_tcs_pkg;

    // Field widths
    localparam int CLK_W     = 27;
    localparam int FREQ_W    = 27;
    localparam int WAVE_W    = 3;
    localparam int CMD_W     = 2;
    localparam int WORD_W    = 16;
    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 3;
    localparam int HALF_W    = 14;

    // Default tuning word width
    localparam int TUNING_BITS_DEF = 28;

    // Reset value of the reference clock register
    localparam logic [CLK_W-1:0] CLOCK_RESET = 27'd25000000;

    // Commands
    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPLY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

    // Waveforms
    localparam logic [WAVE_W-1:0] WAVE_SINE     = 3'd0;
    localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 3'd1;
    localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 3'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_INIT  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD_WAVE  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_ZERO_FREQ = 2'd3;

    // Word slots of an apply sequence
    localparam logic [SLOT_W-1:0] SLOT_CTRL_RST = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_TW_LO    = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_TW_HI    = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_PHASE    = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_CTRL_END = 3'd4;

    // Synthesizer word constants
    localparam logic [WORD_W-1:0] CTRL_BASE     = 16'h2000;
    localparam logic [WORD_W-1:0] CTRL_RESET    = 16'h0100;
    localparam logic [WORD_W-1:0] CTRL_SAFE_OFF = 16'h21C0;
    localparam logic [WORD_W-1:0] CTRL_TRIANGLE = 16'h0002;
    localparam logic [WORD_W-1:0] CTRL_SQUARE   = 16'h0028;
    localparam logic [WORD_W-1:0] FREQ_TAG      = 16'h4000;
    localparam logic [WORD_W-1:0] PHASE_WORD    = 16'hC000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } state_t;

    // Top to divider
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    // Divider to top
    typedef struct packed {
        logic done;
    } div_stat_t;

    // Build the control word for a waveform, with or without reset
    function automatic logic [WORD_W-1:0] ctrl_word(input logic [WAVE_W-1:0] wave,
                                                   input logic rst);
        logic [WORD_W-1:0] c;
        c = CTRL_BASE;
        if (rst) begin
            c = c | CTRL_RESET;
        end
        if (wave == WAVE_TRIANGLE) begin
            c = c | CTRL_TRIANGLE;
        end else if (wave == WAVE_SQUARE) begin
            c = c | CTRL_SQUARE;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/dds_tcs_div.sv
// Bit-serial restoring divider for the tuning word: (f*2^(TB+1)+clk) / (2*clk).
// Depends on dds_tcs_pkg; one quotient bit per cycle, keeps the low TB bits.
`default_nettype none

module dds_tcs_div
    import dds_tcs_pkg::*;
#(
    parameter int TUNING_BITS = TUNING_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire div_ctrl_t              ctrl,
    input  wire logic [FREQ_W-1:0]      freq,
    input  wire logic [CLK_W-1:0]       clk_hz,
    output div_stat_t                   stat,
    output logic [TUNING_BITS-1:0]      quot
);

    // Numerator holds f shifted up by TB+1 plus the rounding term, with one carry bit
    localparam int NUM_W = TUNING_BITS + FREQ_W + 2;
    localparam int CNT_W = $clog2(NUM_W);
    localparam int DIV_W = CLK_W + 1;

    logic [NUM_W-1:0]       num_reg, num_next;
    logic [DIV_W-1:0]       rem_reg, rem_next;
    logic [DIV_W-1:0]       divisor_reg, divisor_next;
    logic [TUNING_BITS-1:0] quot_reg, quot_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;

    logic [DIV_W:0]         trial;
    logic [DIV_W:0]         diff;
    logic                   ge;

    // Shift the next numerator bit into the partial remainder and compare
    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign ge    = (trial >= {1'b0, divisor_reg});

    always_comb begin
        num_next     = num_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        quot_next    = quot_reg;
        cnt_next     = cnt_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        if (ctrl.start) begin
            // Load numerator and divisor, clear remainder
            num_next     = (NUM_W'(freq) << (TUNING_BITS + 1)) + NUM_W'(clk_hz);
            rem_next     = '0;
            divisor_next = {clk_hz, 1'b0};
            cnt_next     = '0;
            busy_next    = 1'b1;
        end else if (busy_reg) begin
            // Advance one quotient bit
            num_next  = {num_reg[NUM_W-2:0], 1'b0};
            rem_next  = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            quot_next = {quot_reg[TUNING_BITS-2:0], ge};
            if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg     <= num_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        quot_reg    <= quot_next;
    end

    assign stat.done = done_reg;
    assign quot      = quot_reg;

endmodule

`default_nettype wire

// File: rtl/dds_tuning_command_sequencer_core.sv
// Top level of the DDS tuning command sequencer: command decode, word sequencing, output register.
// Depends on dds_tcs_pkg and dds_tcs_div.
//
// Usage:
//   The s_ channel carries one command per transfer (start, apply, stop in s_tuser).
//   The m_ channel returns 16-bit synthesizer words; m_tlast marks the final word of a
//   command and m_tuser carries the word-valid flag and the status code. An error gives
//   a single transfer with zero data, word-valid low and the status code.
//   cfg_we/cfg_wdata write the reference clock in hertz (a value of zero acts as one).
// Sequencing:
//   Start, stop and errors: the transfer moves the state to ST_EMIT, which loads the word
//   into the output register, and the next command is taken once the state is back in ST_IDLE.
//   Apply: the tuning word comes from a restoring divider that yields one quotient bit
//   per cycle; the state waits in ST_DIV until the divider is done, then ST_EMIT loads the
//   five words into the output register in turn; the next command is taken after the last.
//   One command is in work at a time; s_tready is high only between commands, and a
//   finished last word may still wait in the output register while the next is taken.
// Reset: clears the initialized flag, sets the clock to 25 MHz and empties the output.
// Stall: while m_tready is low the output word holds and the sequence waits.
`default_nettype none

module dds_tuning_command_sequencer_core
    import dds_tcs_pkg::*;
#(
    parameter int TUNING_BITS = TUNING_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // Configuration
    input  wire logic              cfg_we,
    input  wire logic [CLK_W-1:0]  cfg_wdata,
    // Command channel
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [31:0]       s_tdata,   // [26:0] frequency_hz, [29:27] waveform, [31:30] 0
    input  wire logic [1:0]        s_tuser,   // [1:0] command
    // Word channel
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [15:0]            m_tdata,   // [15:0] spi_word
    output logic                   m_tlast,
    output logic [2:0]             m_tuser    // [0] word_valid, [2:1] status
);

    state_t                 state_reg, state_next;
    logic                   init_reg, init_next;
    logic [CLK_W-1:0]       clock_reg;

    logic                   single_reg, single_next;
    logic [WORD_W-1:0]      pend_word_reg, pend_word_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [STATUS_W-1:0]    pend_status_reg, pend_status_next;
    logic [WAVE_W-1:0]      wave_reg, wave_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;

    logic                   out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]      out_word_reg, out_word_next;
    logic                   out_wvalid_reg, out_wvalid_next;
    logic                   out_last_reg, out_last_next;
    logic [STATUS_W-1:0]    out_status_reg, out_status_next;

    logic [CMD_W-1:0]       s_cmd;
    logic [FREQ_W-1:0]      s_freq;
    logic [WAVE_W-1:0]      s_wave;
    logic                   s_xfer;
    logic                   apply_ok;
    logic                   single_go;
    logic [WORD_W-1:0]      dec_word;
    logic                   dec_valid;
    logic [STATUS_W-1:0]    dec_status;

    logic [CLK_W-1:0]       clk_eff;
    div_ctrl_t              div_ctrl;
    div_stat_t              div_stat;
    logic [TUNING_BITS-1:0] quot;
    logic [TUNING_BITS+27:0] tw_ext;

    logic                   out_free;
    logic                   emit_load;
    logic [WORD_W-1:0]      emit_word;
    logic                   emit_last;

    // Unpack the command transfer
    assign s_cmd  = s_tuser[1:0];
    assign s_freq = s_tdata[26:0];
    assign s_wave = s_tdata[29:27];
    assign s_xfer = s_tvalid && s_tready;

    // Zero clock acts as one
    assign clk_eff = (clock_reg == '0) ? CLK_W'(1) : clock_reg;

    // Decode the command into a single result or a divide
    always_comb begin
        apply_ok   = (s_cmd == CMD_APPLY) && init_reg && (s_wave <= WAVE_SQUARE)
                     && (s_freq != '0);
        single_go  = (s_cmd == CMD_START) || (s_cmd == CMD_STOP)
                     || ((s_cmd == CMD_APPLY) && !apply_ok);
        dec_word   = CTRL_SAFE_OFF;
        dec_valid  = 1'b1;
        dec_status = STAT_OK;
        priority if (s_cmd == CMD_START) begin
            dec_word = CTRL_SAFE_OFF;
        end else if (!init_reg) begin
            dec_word   = '0;
            dec_valid  = 1'b0;
            dec_status = STAT_NOT_INIT;
        end else if (s_cmd == CMD_STOP) begin
            dec_word = CTRL_SAFE_OFF;
        end else if (s_wave > WAVE_SQUARE) begin
            dec_word   = '0;
            dec_valid  = 1'b0;
            dec_status = STAT_BAD_WAVE;
        end else begin
            dec_word   = '0;
            dec_valid  = 1'b0;
            dec_status = STAT_ZERO_FREQ;
        end
    end

    // Tuning word halves, zero-extended so narrow tuning widths still fill both
    assign tw_ext = {28'd0, quot};

    // Select the word for the current slot
    always_comb begin
        unique case (slot_reg)
            SLOT_CTRL_RST: emit_word = ctrl_word(wave_reg, 1'b1);
            SLOT_TW_LO:    emit_word = FREQ_TAG | {2'b00, tw_ext[HALF_W-1:0]};
            SLOT_TW_HI:    emit_word = FREQ_TAG | {2'b00, tw_ext[2*HALF_W-1:HALF_W]};
            SLOT_PHASE:    emit_word = PHASE_WORD;
            SLOT_CTRL_END: emit_word = ctrl_word(wave_reg, 1'b0);
            default:       emit_word = '0;
        endcase
        if (single_reg) begin
            emit_word = pend_word_reg;
        end
        emit_last = single_reg || (slot_reg == SLOT_CTRL_END);
    end

    assign out_free = !out_valid_reg || m_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer && apply_ok) begin
                    state_next = ST_DIV;
                end else if (s_xfer && single_go) begin
                    state_next = ST_EMIT;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free && emit_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_tready       = (state_reg == ST_IDLE);
        div_ctrl.start = (state_reg == ST_IDLE) && s_xfer && apply_ok;
        emit_load      = (state_reg == ST_EMIT) && out_free;
    end

    // Command context and output register updates
    always_comb begin
        init_next        = init_reg;
        single_next      = single_reg;
        pend_word_next   = pend_word_reg;
        pend_valid_next  = pend_valid_reg;
        pend_status_next = pend_status_reg;
        wave_next        = wave_reg;
        slot_next        = slot_reg;
        out_valid_next   = out_valid_reg;
        out_word_next    = out_word_reg;
        out_wvalid_next  = out_wvalid_reg;
        out_last_next    = out_last_reg;
        out_status_next  = out_status_reg;

        // Drop the output word once it is taken
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        // Capture a new command
        if (s_xfer) begin
            if (s_cmd == CMD_START) begin
                init_next = 1'b1;
            end
            single_next      = !apply_ok;
            pend_word_next   = dec_word;
            pend_valid_next  = dec_valid;
            pend_status_next = dec_status;
            wave_next        = s_wave;
            slot_next        = SLOT_CTRL_RST;
        end

        // Load the next word into the output register
        if (emit_load) begin
            out_valid_next  = 1'b1;
            out_word_next   = emit_word;
            out_wvalid_next = single_reg ? pend_valid_reg : 1'b1;
            out_status_next = single_reg ? pend_status_reg : STAT_OK;
            out_last_next   = emit_last;
            slot_next       = slot_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            init_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            single_reg    <= 1'b1;
            slot_reg      <= SLOT_CTRL_RST;
        end else begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            out_valid_reg <= out_valid_next;
            single_reg    <= single_next;
            slot_reg      <= slot_next;
        end
    end

    // Reference clock register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_reg <= CLOCK_RESET;
        end else if (cfg_we) begin
            clock_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        pend_word_reg   <= pend_word_next;
        pend_valid_reg  <= pend_valid_next;
        pend_status_reg <= pend_status_next;
        wave_reg        <= wave_next;
        out_word_reg    <= out_word_next;
        out_wvalid_reg  <= out_wvalid_next;
        out_last_reg    <= out_last_next;
        out_status_reg  <= out_status_next;
    end

    dds_tcs_div #(
        .TUNING_BITS(TUNING_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (div_ctrl),
        .freq    (s_freq),
        .clk_hz  (clk_eff),
        .stat    (div_stat),
        .quot    (quot)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_status_reg, out_wvalid_reg};

endmodule

`default_nettype wire

// File: rtl/dds_tcs_chk.sv
// Port-level checker for the DDS tuning command sequencer, bound to the top level.
// Depends on dds_tcs_pkg for the status codes.
`default_nettype none

module dds_tcs_chk
    import dds_tcs_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic [2:0]  m_tuser
);

    // Hold a stalled word
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
        && $stable(m_tuser))
        else $error("stalled output transfer changed");

    // An error result is a single zero word that ends the command
    a_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata == 16'h0000)
        && (m_tuser[2:1] != STAT_OK))
        else $error("malformed error result");

    // A word with word-valid set always carries an ok status
    a_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tuser[2:1] == STAT_OK))
        else $error("valid word with error status");

    // Reset empties the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind dds_tuning_command_sequencer_core dds_tcs_chk u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// File: tb/tb_dds_tuning_command_sequencer_core.sv
// Self-checking testbench for dds_tuning_command_sequencer_core: a directed command table,
// then random command streams under several reference clocks, with bursty input and stalls.
// Depends on dds_tcs_pkg and the sequencer RTL; needs no files or arguments.
`default_nettype none

module tb_dds_tuning_command_sequencer_core
    import dds_tcs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TUNING_BITS = TUNING_BITS_DEF;

    // Codes the package does not name
    localparam logic [CMD_W-1:0]  CMD_UNKNOWN    = 2'd3;
    localparam logic [WAVE_W-1:0] WAVE_RAMP_UP   = 3'd3;
    localparam logic [WAVE_W-1:0] WAVE_RAMP_DOWN = 3'd4;
    localparam logic [WAVE_W-1:0] WAVE_DC        = 3'd5;
    localparam logic [WAVE_W-1:0] WAVE_INVALID_6 = 3'd6;
    localparam logic [WAVE_W-1:0] WAVE_INVALID_7 = 3'd7;

    localparam logic [FREQ_W-1:0] FREQ_ALL_ONES = 27'h7FFFFFF;
    localparam int DIRECTED_ROWS   = 23;
    localparam int ITEMS_PER_PHASE = 18;
    localparam int SETTLE_CYCLES   = 120;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int HOLD_CYCLES     = 300;

    // One word on the result channel
    typedef struct packed {
        logic [WORD_W-1:0]   word;
        logic                word_valid;
        logic                last;
        logic [STATUS_W-1:0] status;
    } spi_result_t;

    localparam spi_result_t RES_NONE      = '0;
    localparam spi_result_t RES_SAFE_OFF  = '{CTRL_SAFE_OFF, 1'b1, 1'b1, STAT_OK};
    localparam spi_result_t RES_NOT_INIT  = '{16'h0000, 1'b0, 1'b1, STAT_NOT_INIT};
    localparam spi_result_t RES_BAD_WAVE  = '{16'h0000, 1'b0, 1'b1, STAT_BAD_WAVE};
    localparam spi_result_t RES_ZERO_FREQ = '{16'h0000, 1'b0, 1'b1, STAT_ZERO_FREQ};

    // One row of the directed command table
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [FREQ_W-1:0] freq;
        logic [WAVE_W-1:0] wave;
        logic              typed;
        spi_result_t       res;
    } cmd_row_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [CLK_W-1:0]  cfg_wdata = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata   = '0;   // [26:0] frequency_hz, [29:27] waveform, [31:30] 0
    logic [1:0]        s_tuser   = '0;   // [1:0] command
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [15:0]       m_tdata;          // [15:0] spi_word
    logic              m_tlast;
    logic [2:0]        m_tuser;          // [0] word_valid, [2:1] status

    // Predictor state and expected words
    logic [CLK_W-1:0]  ref_clock_hz = CLOCK_RESET;
    logic              dds_ready    = 1'b0;
    spi_result_t       pending_words [$];
    int                fail_count   = 0;
    int                burst_left   = 0;

    // Receiver stall pattern and long hold-off
    logic              hold_request = 1'b0;
    logic              hold_done    = 1'b0;
    int                hold_left    = 0;
    int                stall_mode   = 0;
    int                mode_left    = 0;

    cmd_row_t          directed_rows [0:DIRECTED_ROWS-1];
    logic [CLK_W-1:0]  phase_clocks [0:5];

    dds_tuning_command_sequencer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Abort a hung run
    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Rounded f * 2^TUNING_BITS / clock, wrapped to TUNING_BITS
    function automatic logic [TUNING_BITS-1:0] tuning_word(input logic [FREQ_W-1:0] freq);
        logic [63:0] clk;
        logic [63:0] num;
        clk = {37'd0, ref_clock_hz};
        if (clk == 64'd0) begin
            clk = 64'd1;
        end
        num = ({37'd0, freq} << (TUNING_BITS + 1)) + clk;
        return TUNING_BITS'(num / (clk << 1));
    endfunction

    function automatic logic [WORD_W-1:0] control_word(input logic [WAVE_W-1:0] wave,
                                                        input logic with_reset);
        logic [WORD_W-1:0] c;
        c = CTRL_BASE;
        if (with_reset) begin
            c = c | CTRL_RESET;
        end
        if (wave == WAVE_TRIANGLE) begin
            c = c | CTRL_TRIANGLE;
        end else if (wave == WAVE_SQUARE) begin
            c = c | CTRL_SQUARE;
        end
        return c;
    endfunction

    // Advance the predictor by one command and queue the words it should produce
    task automatic predict_command(input logic [CMD_W-1:0] cmd, input logic [FREQ_W-1:0] freq,
                                   input logic [WAVE_W-1:0] wave, input logic typed,
                                   input spi_result_t typed_res);
        spi_result_t seq [0:4];
        int n;
        logic [TUNING_BITS-1:0] tw;
        n = 0;
        case (cmd)
            CMD_START: begin
                dds_ready = 1'b1;
                seq[0] = RES_SAFE_OFF;
                n = 1;
            end
            CMD_STOP: begin
                seq[0] = dds_ready ? RES_SAFE_OFF : RES_NOT_INIT;
                n = 1;
            end
            CMD_APPLY: begin
                n = 1;
                if (!dds_ready) begin
                    seq[0] = RES_NOT_INIT;
                end else if (wave > WAVE_SQUARE) begin
                    seq[0] = RES_BAD_WAVE;
                end else if (freq == '0) begin
                    seq[0] = RES_ZERO_FREQ;
                end else begin
                    tw = tuning_word(freq);
                    seq[0] = '{control_word(wave, 1'b1), 1'b1, 1'b0, STAT_OK};
                    seq[1] = '{FREQ_TAG | {2'b00, tw[HALF_W-1:0]}, 1'b1, 1'b0, STAT_OK};
                    seq[2] = '{FREQ_TAG | {2'b00, tw[2*HALF_W-1:HALF_W]}, 1'b1, 1'b0, STAT_OK};
                    seq[3] = '{PHASE_WORD, 1'b1, 1'b0, STAT_OK};
                    seq[4] = '{control_word(wave, 1'b0), 1'b1, 1'b1, STAT_OK};
                    n = 5;
                end
            end
            default: begin
                n = 0;
            end
        endcase
        if (typed) begin
            pending_words.push_back(typed_res);
        end else begin
            for (int i = 0; i < n; i++) begin
                pending_words.push_back(seq[i]);
            end
        end
    endtask

    // Offer one command, wait for the transfer, then idle at the end of a burst
    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [FREQ_W-1:0] freq,
                                input logic [WAVE_W-1:0] wave, input logic typed,
                                input spi_result_t typed_res);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, wave, freq};
        do @(posedge aclk); while (!s_tready);
        predict_command(cmd, freq, wave, typed, typed_res);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 70)) @(posedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_for_drain();
        int waited;
        waited = 0;
        while (pending_words.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
    endtask

    // Write the reference clock once the block has gone quiet
    task automatic set_ref_clock(input logic [CLK_W-1:0] value);
        s_tvalid <= 1'b0;
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        ref_clock_hz = value;
    endtask

    // Mostly well-formed commands, with malformed applies and unknown codes mixed in
    task automatic pick_random_command(output logic [CMD_W-1:0] cmd,
                                       output logic [FREQ_W-1:0] freq,
                                       output logic [WAVE_W-1:0] wave);
        int sel;
        sel  = $urandom_range(0, 99);
        wave = WAVE_W'($urandom_range(0, 2));
        case ($urandom_range(0, 3))
            0: freq = FREQ_W'($urandom_range(1, 1000));
            1: freq = FREQ_W'($urandom);
            2: freq = FREQ_W'($urandom_range(1, 100000000));
            default: freq = ref_clock_hz + FREQ_W'($urandom_range(0, 2)) - FREQ_W'(1);
        endcase
        if (freq == '0) begin
            freq = FREQ_W'(1);
        end
        if (sel < 8) begin
            cmd  = CMD_START;
            wave = WAVE_W'($urandom);
        end else if (sel < 16) begin
            cmd  = CMD_STOP;
            wave = WAVE_W'($urandom);
        end else if (sel < 84) begin
            cmd  = CMD_APPLY;
        end else if (sel < 92) begin
            cmd  = CMD_APPLY;
            wave = WAVE_W'($urandom_range(WAVE_RAMP_UP, WAVE_INVALID_7));
        end else if (sel < 96) begin
            cmd  = CMD_APPLY;
            freq = '0;
        end else begin
            cmd  = CMD_UNKNOWN;
            wave = WAVE_W'($urandom);
        end
    endtask

    // Receiver: ready pattern that changes mode now and then, plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_request && !hold_done) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 2);
                mode_left  <= $urandom_range(10, 60);
            end else begin
                mode_left  <= mode_left - 1;
            end
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Check each output transfer against the oldest expected word
    always @(posedge aclk) begin : word_checker
        spi_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_words.size() == 0) begin
                $error("unexpected transfer: spi_word %h, tuser %b", m_tdata, m_tuser);
                fail_count++;
            end else begin
                want = pending_words.pop_front();
                if (m_tdata !== want.word) begin
                    $error("spi_word: expected %h, got %h", want.word, m_tdata);
                    fail_count++;
                end
                if (m_tuser[0] !== want.word_valid) begin
                    $error("word_valid: expected %b, got %b", want.word_valid, m_tuser[0]);
                    fail_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %b, got %b", want.last, m_tlast);
                    fail_count++;
                end
                if (m_tuser[2:1] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser[2:1]);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus
    initial begin
        logic [CMD_W-1:0]  cmd;
        logic [FREQ_W-1:0] freq;
        logic [WAVE_W-1:0] wave;
        int counted;

        // Errors before start, start, every waveform check, extremes of frequency
        directed_rows = '{
            '{CMD_STOP,    27'd0,         WAVE_SINE,      1'b1, RES_NOT_INIT},
            '{CMD_APPLY,   27'd1000,      WAVE_SINE,      1'b1, RES_NOT_INIT},
            '{CMD_APPLY,   27'd0,         WAVE_INVALID_7, 1'b1, RES_NOT_INIT},
            '{CMD_START,   FREQ_ALL_ONES, WAVE_INVALID_7, 1'b1, RES_SAFE_OFF},
            '{CMD_START,   27'd0,         WAVE_SINE,      1'b1, RES_SAFE_OFF},
            '{CMD_APPLY,   27'd1000,      WAVE_RAMP_UP,   1'b1, RES_BAD_WAVE},
            '{CMD_APPLY,   FREQ_ALL_ONES, WAVE_RAMP_DOWN, 1'b1, RES_BAD_WAVE},
            '{CMD_APPLY,   27'd1,         WAVE_DC,        1'b1, RES_BAD_WAVE},
            '{CMD_APPLY,   27'd0,         WAVE_INVALID_6, 1'b1, RES_BAD_WAVE},
            '{CMD_APPLY,   27'd12345,     WAVE_INVALID_7, 1'b1, RES_BAD_WAVE},
            '{CMD_APPLY,   27'd0,         WAVE_SINE,      1'b1, RES_ZERO_FREQ},
            '{CMD_APPLY,   27'd1,         WAVE_SINE,      1'b0, RES_NONE},
            '{CMD_APPLY,   27'd1000000,   WAVE_TRIANGLE,  1'b0, RES_NONE},
            '{CMD_APPLY,   27'd12500000,  WAVE_SQUARE,    1'b0, RES_NONE},
            '{CMD_APPLY,   27'd100000000, WAVE_SINE,      1'b0, RES_NONE},
            '{CMD_APPLY,   FREQ_ALL_ONES, WAVE_TRIANGLE,  1'b0, RES_NONE},
            '{CMD_APPLY,   27'h5555555,   WAVE_SQUARE,    1'b0, RES_NONE},
            '{CMD_APPLY,   27'h2AAAAAA,   WAVE_SINE,      1'b0, RES_NONE},
            '{CMD_UNKNOWN, FREQ_ALL_ONES, WAVE_INVALID_7, 1'b0, RES_NONE},
            '{CMD_STOP,    27'd0,         WAVE_SINE,      1'b1, RES_SAFE_OFF},
            '{CMD_APPLY,   27'd25000000,  WAVE_SQUARE,    1'b0, RES_NONE},
            '{CMD_UNKNOWN, 27'd0,         WAVE_SINE,      1'b0, RES_NONE},
            '{CMD_START,   27'd0,         WAVE_SINE,      1'b1, RES_SAFE_OFF}
        };
        // Clock extremes: top of range, one, beyond range, zero, tiny, random
        phase_clocks = '{27'd100000000, 27'd1, 27'h7FFFFFF, 27'd0, 27'd3, 27'd25000000};
        phase_clocks[5] = CLK_W'($urandom_range(1, 100000000));

        // Hold reset, then release it
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        burst_left = $urandom_range(1, 8);
        foreach (directed_rows[i]) begin
            send_command(directed_rows[i].cmd, directed_rows[i].freq, directed_rows[i].wave,
                         directed_rows[i].typed, directed_rows[i].res);
        end

        foreach (phase_clocks[p]) begin
            set_ref_clock(phase_clocks[p]);
            if (p == 0) begin
                // Keep offering commands while the receiver holds off
                hold_request <= 1'b1;
                burst_left = 30;
            end
            counted = 0;
            while (counted < ITEMS_PER_PHASE) begin
                pick_random_command(cmd, freq, wave);
                send_command(cmd, freq, wave, 1'b0, RES_NONE);
                if (cmd != CMD_UNKNOWN) begin
                    counted++;
                end
            end
        end

        // Drain, then watch for stray words
        s_tvalid <= 1'b0;
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_words.size() != 0) begin
            $error("%0d expected words never arrived", pending_words.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
rtl/dds_tcs_pkg.sv
rtl/dds_tcs_div.sv
rtl/dds_tuning_command_sequencer_core.sv
rtl/dds_tcs_chk.sv
tb/tb_dds_tuning_command_sequencer_core.sv
